// ===== design/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising edge of clk_i, quiet while rst_ni is low.
`define ASSERT_RST(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`else

`define ASSERT_RST(name, prop, msg)
`define ASSERT_ALWAYS(name, prop, msg)

`endif

`endif

// ===== design/gra_pkg.sv =====
// Shared constants, types and control structs of the grid rectangle allocator.
// No dependencies; used by gra_ctrl, gra_datapath and the top level.
`timescale 1ns / 1ps

package gra_pkg;

  localparam int GRID_ROWS = 4;
  localparam int GRID_COLS = 10;

  localparam int OP_W  = 2;
  localparam int COL_W = 4;
  localparam int ROW_W = 2;
  localparam int WID_W = 4;
  localparam int HGT_W = 3;

  localparam logic [OP_W-1:0] OP_CHECK = 2'd0;
  localparam logic [OP_W-1:0] OP_PLACE = 2'd1;
  localparam logic [OP_W-1:0] OP_FIRST = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd3;

  typedef logic [COL_W:0]       col_sum_t;
  typedef logic [HGT_W:0]       row_sum_t;
  typedef logic [GRID_COLS-1:0] grid_row_t;

  typedef struct packed {
    logic [HGT_W-1:0] hgt;
    logic [WID_W-1:0] wid;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic [OP_W-1:0]  op;
  } gra_req_t;

  typedef struct packed {
    logic start;     // capture a new request
    logic acc;       // OR one occupancy row into the union
    logic next_col;  // move the candidate one column right
    logic next_row;  // move the candidate to the next row, column zero
    logic rewind;    // restart the row counter
    logic mark;      // set the span in one row
    logic clear;     // free the span in one row
    logic finish;    // load the result register
    logic ok;        // success flag for finish
  } gra_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic size_ok;
    logic hgt_zero;
    logic bounds_ok;
    logic fit;
    logic cnt_last;
    logic col_more;
    logic row_more;
    logic out_busy;
  } gra_status_t;

endpackage

// ===== design/gra_datapath.sv =====
// Datapath of the allocator: request registers, occupancy rows, union and result register.
// Depends on gra_pkg; driven by gra_ctrl through gra_cmd_t.
`timescale 1ns / 1ps

module gra_datapath
  import gra_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gra_req_t         req_i,
  input  gra_cmd_t         cmd_i,
  output gra_status_t      st_o,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             out_success_o,
  output logic [COL_W-1:0] out_col_o,
  output logic [ROW_W-1:0] out_row_o
);

  logic [OP_W-1:0]  op_q;
  logic [WID_W-1:0] wid_q;
  logic [HGT_W-1:0] hgt_q;
  logic [COL_W-1:0] base_col_q, base_col_d;
  logic [ROW_W-1:0] base_row_q, base_row_d;
  logic [HGT_W-1:0] cnt_q, cnt_d;
  grid_row_t        union_q, union_d;
  grid_row_t        occ_q [GRID_ROWS];

  logic             out_valid_q;
  logic             out_success_q;
  logic [COL_W-1:0] out_col_q;
  logic [ROW_W-1:0] out_row_q;

  col_sum_t         col_end;
  col_sum_t         col_next_end;
  row_sum_t         row_end;
  row_sum_t         row_next_end;
  row_sum_t         cur_row;
  logic [ROW_W-1:0] cur_idx;
  logic             row_in_grid;
  grid_row_t        span;
  grid_row_t        row_rd;

  assign col_end      = col_sum_t'(base_col_q) + col_sum_t'(wid_q);
  assign col_next_end = col_end + col_sum_t'(1);
  assign row_end      = row_sum_t'(base_row_q) + row_sum_t'(hgt_q);
  assign row_next_end = row_end + row_sum_t'(1);
  assign cur_row      = row_sum_t'(base_row_q) + row_sum_t'(cnt_q);
  assign cur_idx      = cur_row[ROW_W-1:0];
  assign row_in_grid  = cur_row < row_sum_t'(GRID_ROWS);
  assign row_rd       = occ_q[cur_idx];

  // Columns covered by the rectangle; columns past the grid edge simply drop out.
  always_comb begin
    for (int j = 0; j < GRID_COLS; j++) begin
      span[j] = (col_sum_t'(j) >= col_sum_t'(base_col_q)) && (col_sum_t'(j) < col_end);
    end
  end

  always_comb begin
    st_o.op        = op_q;
    st_o.size_ok   = (wid_q != '0) && (hgt_q != '0);
    st_o.hgt_zero  = (hgt_q == '0);
    st_o.bounds_ok = (col_end <= col_sum_t'(GRID_COLS)) && (row_end <= row_sum_t'(GRID_ROWS));
    st_o.fit       = (union_q & span) == '0;
    st_o.cnt_last  = cnt_q == (hgt_q - HGT_W'(1));
    st_o.col_more  = col_next_end <= col_sum_t'(GRID_COLS);
    st_o.row_more  = row_next_end <= row_sum_t'(GRID_ROWS);
    st_o.out_busy  = out_valid_q && !out_ready_i;
  end

  always_comb begin
    base_col_d = base_col_q;
    base_row_d = base_row_q;
    cnt_d      = cnt_q;
    union_d    = union_q;
    if (cmd_i.start) begin
      base_col_d = (req_i.op == OP_FIRST) ? '0 : req_i.col;
      base_row_d = (req_i.op == OP_FIRST) ? '0 : req_i.row;
      cnt_d      = '0;
      union_d    = '0;
    end else if (cmd_i.next_row) begin
      base_col_d = '0;
      base_row_d = base_row_q + ROW_W'(1);
      cnt_d      = '0;
      union_d    = '0;
    end else begin
      if (cmd_i.next_col) begin
        base_col_d = base_col_q + COL_W'(1);
      end
      if (cmd_i.rewind) begin
        cnt_d = '0;
      end else if (cmd_i.acc || cmd_i.mark || cmd_i.clear) begin
        cnt_d = cnt_q + HGT_W'(1);
      end
      if (cmd_i.acc) begin
        union_d = union_q | row_rd;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      op_q  <= req_i.op;
      wid_q <= req_i.wid;
      hgt_q <= req_i.hgt;
    end
    base_col_q <= base_col_d;
    base_row_q <= base_row_d;
    cnt_q      <= cnt_d;
    union_q    <= union_d;
  end

  // One occupancy row is written per cycle, at the row the counter points to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < GRID_ROWS; r++) begin
        occ_q[r] <= '0;
      end
    end else if (cmd_i.mark) begin
      occ_q[cur_idx] <= row_rd | span;
    end else if (cmd_i.clear && row_in_grid) begin
      occ_q[cur_idx] <= row_rd & ~span;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_success_q <= cmd_i.ok;
      out_col_q     <= cmd_i.ok ? base_col_q : '0;
      out_row_q     <= cmd_i.ok ? base_row_q : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_success_o = out_success_q;
  assign out_col_o     = out_col_q;
  assign out_row_o     = out_row_q;

endmodule

// ===== design/gra_ctrl.sv =====
// Controller state machine of the allocator: sequences accumulate, test, mark and clear.
// Depends on gra_pkg and assert_macros.svh; steers gra_datapath.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gra_ctrl
  import gra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  gra_status_t st_i,
  output gra_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_ACC    = 3'd2;
  localparam logic [2:0] S_TEST   = 3'd3;
  localparam logic [2:0] S_MARK   = 3'd4;
  localparam logic [2:0] S_CLEAR  = 3'd5;
  localparam logic [2:0] S_OK     = 3'd6;
  localparam logic [2:0] S_FAIL   = 3'd7;

  logic [2:0] state_q, state_d;

  assign req_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st_i.op == OP_CLEAR) begin
          state_d = st_i.hgt_zero ? S_OK : S_CLEAR;
        end else if (st_i.size_ok && st_i.bounds_ok) begin
          state_d = S_ACC;
        end else begin
          state_d = S_FAIL;
        end
      end
      S_ACC: begin
        cmd_o.acc = 1'b1;
        if (st_i.cnt_last) begin
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (st_i.fit) begin
          if (st_i.op == OP_CHECK) begin
            state_d = S_OK;
          end else begin
            cmd_o.rewind = 1'b1;
            state_d      = S_MARK;
          end
        end else if (st_i.op == OP_FIRST && st_i.col_more) begin
          cmd_o.next_col = 1'b1;
        end else if (st_i.op == OP_FIRST && st_i.row_more) begin
          cmd_o.next_row = 1'b1;
          state_d        = S_ACC;
        end else begin
          state_d = S_FAIL;
        end
      end
      S_MARK: begin
        cmd_o.mark = 1'b1;
        if (st_i.cnt_last) begin
          state_d = S_OK;
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (st_i.cnt_last) begin
          state_d = S_OK;
        end
      end
      S_OK, S_FAIL: begin
        // Wait until the result register is free, then hand the result over.
        if (!st_i.out_busy) begin
          cmd_o.finish = 1'b1;
          cmd_o.ok     = (state_q == S_OK);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_RST(a_finish_free, cmd_o.finish |-> !st_i.out_busy, "result overwritten while stalled")
  `ASSERT_RST(a_scan_in_bounds, (state_q == S_ACC || state_q == S_TEST) |-> st_i.bounds_ok, "candidate outside grid")
  `ASSERT_RST(a_mark_op, state_q == S_MARK |-> (st_i.op == OP_PLACE || st_i.op == OP_FIRST), "mark on wrong op")
  `ASSERT_ALWAYS(a_ready_idle, req_ready_o |-> !cmd_o.mark && !cmd_o.clear && !cmd_o.acc, "busy while ready")

endmodule

// ===== design/grid_rectangle_allocator.sv =====
// Grid rectangle allocator: an occupancy bitmap of 4 rows by 10 columns (free after reset)
// serving check, place, first-fit place and clear requests, one request at a time. The
// occupancy is read and written one row per cycle, and a candidate position is tested one
// column per cycle against the union of the rows it covers. A finished result waits in an
// output register; the next request is taken meanwhile. Depends on gra_pkg, gra_ctrl and
// gra_datapath.
`timescale 1ns / 1ps

module grid_rectangle_allocator
  import gra_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // col_index[3:0], row_index[5:4], rect_width[9:6],
                                     // rect_height[12:10], zero[15:13]
  input  logic [1:0]  s_axis_tuser,  // operation[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // placed_col[3:0], placed_row[5:4], zero[7:6]
  output logic        m_axis_tuser   // success
);

  gra_req_t         req;
  gra_cmd_t         cmd;
  gra_status_t      st;
  logic [COL_W-1:0] out_col;
  logic [ROW_W-1:0] out_row;

  assign req.op  = s_axis_tuser;
  assign req.col = s_axis_tdata[3:0];
  assign req.row = s_axis_tdata[5:4];
  assign req.wid = s_axis_tdata[9:6];
  assign req.hgt = s_axis_tdata[12:10];

  gra_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .st_i        (st),
    .cmd_o       (cmd)
  );

  gra_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .cmd_i         (cmd),
    .st_o          (st),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_success_o (m_axis_tuser),
    .out_col_o     (out_col),
    .out_row_o     (out_row)
  );

  assign m_axis_tdata = {2'b00, out_row, out_col};

endmodule
